// ===== sv/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the cache tag store
// Sizes of the tag memory, channel word layouts, register map and row format.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SETS  = 256;
    localparam int MAX_WAYS  = 8;
    localparam int ROW_W     = $clog2(MAX_SETS);
    localparam int AGE_W     = $clog2(MAX_WAYS);
    localparam int WAYS_W    = $clog2(MAX_WAYS + 1);
    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int TIME_W    = 11;
    localparam int REG_CNT   = 5;
    localparam int PADDR_W   = $clog2(4 * REG_CNT);
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int SHIFT_W   = 5;

    localparam logic FUNC_DEMAND   = 1'b0;
    localparam logic FUNC_PREFETCH = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_INDEX_BITS   = 3'd0,
        REG_OFFSET_BITS  = 3'd1,
        REG_WAYS_IN_USE  = 3'd2,
        REG_HIT_TIME     = 3'd3,
        REG_MISS_PENALTY = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [3:0] index_bits;
        logic [2:0] offset_bits;
        logic [3:0] ways_in_use;
        logic [7:0] hit_time;
        logic [9:0] miss_penalty;
    } cfg_t;

    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] address;
    } in_t;

    typedef struct packed {
        logic              hit;
        logic [TIME_W-1:0] access_time;
    } out_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
        logic [MAX_WAYS-1:0]            valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    } row_t;

    localparam int ROW_BITS = $bits(row_t);

    // contents of a row that was never written since reset
    function automatic row_t row_reset_value();
        row_t r;
        r = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            r.age[w] = AGE_W'(w);
        end
        return r;
    endfunction

endpackage

// ===== sv/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/salc_cfg.sv =====
// ----------------------------------------------------------------------------
// salc_cfg: configuration registers behind an apb-style port
// Five registers at word addresses, written on the access cycle, read back.
// ----------------------------------------------------------------------------
module salc_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [salc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output salc_pkg::cfg_t               cfg
);

    salc_pkg::cfg_t     cfg_reg;
    salc_pkg::reg_idx_t reg_idx;
    logic               wr_en;

    assign reg_idx = salc_pkg::reg_idx_t'(paddr[salc_pkg::PADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.index_bits   <= 4'd6;
            cfg_reg.offset_bits  <= 3'd5;
            cfg_reg.ways_in_use  <= 4'd4;
            cfg_reg.hit_time     <= 8'd1;
            cfg_reg.miss_penalty <= 10'd100;
        end else if (wr_en) begin
            unique case (reg_idx)
                salc_pkg::REG_INDEX_BITS:   cfg_reg.index_bits   <= pwdata[3:0];
                salc_pkg::REG_OFFSET_BITS:  cfg_reg.offset_bits  <= pwdata[2:0];
                salc_pkg::REG_WAYS_IN_USE:  cfg_reg.ways_in_use  <= pwdata[3:0];
                salc_pkg::REG_HIT_TIME:     cfg_reg.hit_time     <= pwdata[7:0];
                salc_pkg::REG_MISS_PENALTY: cfg_reg.miss_penalty <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            salc_pkg::REG_INDEX_BITS:   prdata = 32'(cfg_reg.index_bits);
            salc_pkg::REG_OFFSET_BITS:  prdata = 32'(cfg_reg.offset_bits);
            salc_pkg::REG_WAYS_IN_USE:  prdata = 32'(cfg_reg.ways_in_use);
            salc_pkg::REG_HIT_TIME:     prdata = 32'(cfg_reg.hit_time);
            salc_pkg::REG_MISS_PENALTY: prdata = 32'(cfg_reg.miss_penalty);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ===== sv/salc_row_update.sv =====
// ----------------------------------------------------------------------------
// salc_row_update: tag compare, victim choice and age update of one set
// Takes the row read from the tag memory and forms the row to write back.
// ----------------------------------------------------------------------------
module salc_row_update (
    input  salc_pkg::row_t                   row_in,
    input  logic [salc_pkg::TAG_W-1:0]       tag,
    input  logic                             prefetch,
    input  logic [3:0]                       ways_in_use,
    output salc_pkg::row_t                   row_out,
    output logic                             hit
);

    localparam int W = salc_pkg::MAX_WAYS;

    logic [salc_pkg::WAYS_W-1:0] nways;
    logic [W-1:0]                in_use;
    logic [W-1:0]                match;
    logic [W-1:0]                age_zero;
    logic [salc_pkg::AGE_W-1:0]  hit_way;
    logic [salc_pkg::AGE_W-1:0]  victim;
    logic [salc_pkg::AGE_W-1:0]  way;
    logic [salc_pkg::AGE_W-1:0]  old_age;
    logic [salc_pkg::AGE_W-1:0]  top_age;
    logic                        promote;

    always_comb begin
        // zero ways acts as one, too many acts as the full set
        if (ways_in_use == '0) begin
            nways = salc_pkg::WAYS_W'(1);
        end else if (32'(ways_in_use) > W) begin
            nways = salc_pkg::WAYS_W'(W);
        end else begin
            nways = salc_pkg::WAYS_W'(ways_in_use);
        end
    end

    always_comb begin
        for (int i = 0; i < W; i++) begin
            in_use[i]   = i < int'(nways);
            match[i]    = in_use[i] && row_in.valid[i] && (row_in.tag[i] == tag);
            age_zero[i] = in_use[i] && (row_in.age[i] == '0);
        end
    end

    // lowest-numbered way wins in both searches
    always_comb begin
        hit_way = '0;
        victim  = '0;
        for (int i = W - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_way = salc_pkg::AGE_W'(i);
            end
            if (age_zero[i]) begin
                victim = salc_pkg::AGE_W'(i);
            end
        end
    end

    assign hit     = |match;
    assign way     = hit ? hit_way : victim;
    assign old_age = row_in.age[way];
    assign top_age = salc_pkg::AGE_W'(nways - salc_pkg::WAYS_W'(1));
    assign promote = !hit || !prefetch;

    always_comb begin
        row_out = row_in;
        if (!hit) begin
            row_out.tag[way]   = tag;
            row_out.valid[way] = 1'b1;
        end
        if (promote) begin
            for (int i = 0; i < W; i++) begin
                if (in_use[i]) begin
                    if (salc_pkg::AGE_W'(i) == way) begin
                        row_out.age[i] = top_age;
                    end else if (row_in.age[i] > old_age) begin
                        row_out.age[i] = row_in.age[i] - salc_pkg::AGE_W'(1);
                    end
                end
            end
        end
    end

endmodule

// ===== sv/set_assoc_lru_cache_tags.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: tag store of a set-associative lru cache
// Looks up demand accesses and prefetch fills, fills on miss, keeps ages.
// ----------------------------------------------------------------------------
// Input words (s_ channel) carry func (0 demand, 1 prefetch) and a byte
// address. Each accepted word gives exactly one result word on the m_
// channel: the hit flag and the access time (hit_time, plus miss_penalty on
// a demand miss, 0 for a prefetch).
// Each set is one row of the tag memory holding tags, valid bits and ages
// of all ways. A word is taken while its row is read; in ST_LOOKUP, once the
// output register is free, the block compares, picks the victim, writes the
// row back and loads the result register. The input is taken again only
// after the read-modify-write on the single row memory, so an access to the
// same set always sees the previous update. If the receiver stalls, the
// result waits in the output register; one more word can be accepted and
// read, then the block holds until the result is taken. After reset every
// row reads as empty with ages equal to the way number, through per-row
// init flags; no clearing pass is needed. The user must write registers
// through the apb port only while the block is idle; the block does not
// enforce this.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  salc_pkg::in_t                s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output salc_pkg::out_t               m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [salc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int ROW_W = salc_pkg::ROW_W;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    salc_pkg::cfg_t             cfg;
    state_t                     state_reg;
    logic                       func_reg;
    logic [salc_pkg::TAG_W-1:0] tag_reg;
    logic [ROW_W-1:0]           row_reg;
    logic                       m_valid_reg;
    salc_pkg::out_t             m_data_reg;
    logic [salc_pkg::MAX_SETS-1:0] row_init_reg;

    logic                          accept;
    logic                          done;
    logic [salc_pkg::ADDR_W-1:0]   shifted;
    logic [ROW_W-1:0]              set_mask;
    logic [ROW_W-1:0]              row_sel;
    logic [salc_pkg::SHIFT_W-1:0]  tag_shift;
    logic [salc_pkg::TAG_W-1:0]    tag_sel;
    logic [salc_pkg::ROW_BITS-1:0] rd_data;
    salc_pkg::row_t                row_cur;
    salc_pkg::row_t                row_new;
    logic                          hit;
    logic [salc_pkg::TIME_W-1:0]   time_next;

    salc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // address split: sets beyond the store wrap onto its rows
    always_comb begin
        shifted = s_data.address >> cfg.offset_bits;
        for (int i = 0; i < ROW_W; i++) begin
            set_mask[i] = i < int'(cfg.index_bits);
        end
        row_sel   = shifted[ROW_W-1:0] & set_mask;
        tag_shift = salc_pkg::SHIFT_W'(cfg.offset_bits) + salc_pkg::SHIFT_W'(cfg.index_bits);
        tag_sel   = s_data.address >> tag_shift;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign done    = (state_reg == ST_LOOKUP) && (!m_valid_reg || m_ready);

    salc_ram #(
        .WIDTH (salc_pkg::ROW_BITS),
        .DEPTH (salc_pkg::MAX_SETS)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (done),
        .waddr (row_reg),
        .wdata (row_new),
        .re    (accept),
        .raddr (row_sel),
        .rdata (rd_data)
    );

    assign row_cur = row_init_reg[row_reg] ? salc_pkg::row_t'(rd_data)
                                           : salc_pkg::row_reset_value();

    salc_row_update u_row_update (
        .row_in      (row_cur),
        .tag         (tag_reg),
        .prefetch    (func_reg == salc_pkg::FUNC_PREFETCH),
        .ways_in_use (cfg.ways_in_use),
        .row_out     (row_new),
        .hit         (hit)
    );

    always_comb begin
        if (func_reg == salc_pkg::FUNC_PREFETCH) begin
            time_next = '0;
        end else if (hit) begin
            time_next = salc_pkg::TIME_W'(cfg.hit_time);
        end else begin
            time_next = salc_pkg::TIME_W'(cfg.hit_time) + salc_pkg::TIME_W'(cfg.miss_penalty);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            m_data_reg   <= '0;
            row_init_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_LOOKUP;
                    end
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                ST_LOOKUP: begin
                    if (done) begin
                        state_reg              <= ST_IDLE;
                        m_valid_reg            <= 1'b1;
                        m_data_reg.hit         <= hit;
                        m_data_reg.access_time <= time_next;
                        row_init_reg[row_reg]  <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_data.func;
            tag_reg  <= tag_sel;
            row_reg  <= row_sel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
